FILE: rtl/core/fss_pkg.sv
// ----------------------------------------------------------------------------
// Fan start and stall supervisor package
// Field widths, register map and supervisor state codes shared by the block.
// ----------------------------------------------------------------------------
`default_nettype none

package fss_pkg;

  localparam int unsigned REQ_W   = 16;
  localparam int unsigned DRIVE_W = 8;
  localparam int unsigned RPM_W   = 20;
  localparam int unsigned STATE_W = 3;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned EDGE_W  = 8;

  localparam int unsigned APB_AW  = 5;
  localparam int unsigned APB_DW  = 32;

  // Register index, taken from paddr[4:2]
  localparam logic [2:0] REG_START_TIMEOUT    = 3'd0;
  localparam logic [2:0] REG_START_EDGES      = 3'd1;
  localparam logic [2:0] REG_STABILIZE_DELAY  = 3'd2;
  localparam logic [2:0] REG_MEASURE_INTERVAL = 3'd3;
  localparam logic [2:0] REG_MIN_RPM          = 3'd4;
  localparam logic [2:0] REG_MAX_RPM          = 3'd5;

  localparam logic [CNT_W-1:0]  START_TIMEOUT_RST    = 16'd1000;
  localparam logic [EDGE_W-1:0] START_EDGES_RST      = 8'd8;
  localparam logic [CNT_W-1:0]  STABILIZE_DELAY_RST  = 16'd1000;
  localparam logic [CNT_W-1:0]  MEASURE_INTERVAL_RST = 16'd1000;
  localparam logic [CNT_W-1:0]  MIN_RPM_RST          = 16'd0;
  localparam logic [CNT_W-1:0]  MAX_RPM_RST          = 16'hFFFF;

  localparam logic [DRIVE_W-1:0] DRIVE_FULL = 8'd255;

  typedef enum logic [STATE_W-1:0] {
    ST_IDLE        = 3'd0,
    ST_STARTING    = 3'd1,
    ST_STABILIZING = 3'd2,
    ST_RUNNING     = 3'd3,
    ST_START_ERR   = 3'd4,
    ST_RUN_ERR     = 3'd5
  } fan_state_t;

  // What the tachometer reports for the tick being taken
  typedef struct packed {
    logic             edge_seen;
    logic [RPM_W-1:0] rpm;
  } tach_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/fss_if.sv
// ----------------------------------------------------------------------------
// Fan start and stall supervisor channels
// Valid/ready channels for the tick samples and for the status results.
// ----------------------------------------------------------------------------
`default_nettype none

interface fss_tick_if;
  logic                      valid;
  logic                      ready;
  logic                      tach_level;
  logic [fss_pkg::REQ_W-1:0] pwm_request;

  modport source (output valid, tach_level, pwm_request, input ready);
  modport sink   (input valid, tach_level, pwm_request, output ready);
endinterface

interface fss_status_if;
  logic                        valid;
  logic                        ready;
  logic [fss_pkg::STATE_W-1:0] fan_state;
  logic [fss_pkg::DRIVE_W-1:0] drive_level;
  logic [fss_pkg::RPM_W-1:0]   measured_rpm;
  logic                        tach_edge;

  modport source (output valid, fan_state, drive_level, measured_rpm, tach_edge,
                  input ready);
  modport sink   (input valid, fan_state, drive_level, measured_rpm, tach_edge,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/fan_start_stall_supervisor.sv
// Latency: a tick's status is valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle; the status register is the only stage, and a
// new tick is taken whenever that register is empty or being emptied.
// Reset (rst, synchronous): supervisor idle, all counters and rpm zero,
// configuration registers at their documented defaults, no status pending.
// ----------------------------------------------------------------------------
// Fan start and stall supervisor
// Spin-up, stabilisation and stall supervision of a fan from tachometer ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_start_stall_supervisor (
  input  wire logic                           clk,
  input  wire logic                           rst,
  fss_tick_if.sink                            tick,
  fss_status_if.source                        status,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [fss_pkg::APB_AW-1:0]     paddr,
  input  wire logic [fss_pkg::APB_DW-1:0]     pwdata,
  output logic      [fss_pkg::APB_DW-1:0]     prdata,
  output logic                                pready
);

  // Configuration registers
  logic [fss_pkg::CNT_W-1:0]  spinup_limit;
  logic [fss_pkg::EDGE_W-1:0] spinup_edges;
  logic [fss_pkg::CNT_W-1:0]  stabilize_delay;
  logic [fss_pkg::CNT_W-1:0]  measure_interval;
  logic [fss_pkg::CNT_W-1:0]  min_rpm;
  logic [fss_pkg::CNT_W-1:0]  max_rpm;

  logic       cfg_write;
  logic [2:0] reg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_index = paddr[fss_pkg::APB_AW-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      spinup_limit     <= fss_pkg::START_TIMEOUT_RST;
      spinup_edges     <= fss_pkg::START_EDGES_RST;
      stabilize_delay  <= fss_pkg::STABILIZE_DELAY_RST;
      measure_interval <= fss_pkg::MEASURE_INTERVAL_RST;
      min_rpm          <= fss_pkg::MIN_RPM_RST;
      max_rpm          <= fss_pkg::MAX_RPM_RST;
    end else if (cfg_write) begin
      case (reg_index)
        fss_pkg::REG_START_TIMEOUT:    spinup_limit     <= pwdata[fss_pkg::CNT_W-1:0];
        fss_pkg::REG_START_EDGES:      spinup_edges     <= pwdata[fss_pkg::EDGE_W-1:0];
        fss_pkg::REG_STABILIZE_DELAY:  stabilize_delay  <= pwdata[fss_pkg::CNT_W-1:0];
        fss_pkg::REG_MEASURE_INTERVAL: measure_interval <= pwdata[fss_pkg::CNT_W-1:0];
        fss_pkg::REG_MIN_RPM:          min_rpm          <= pwdata[fss_pkg::CNT_W-1:0];
        fss_pkg::REG_MAX_RPM:          max_rpm          <= pwdata[fss_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_index)
      fss_pkg::REG_START_TIMEOUT:    prdata = {16'b0, spinup_limit};
      fss_pkg::REG_START_EDGES:      prdata = {24'b0, spinup_edges};
      fss_pkg::REG_STABILIZE_DELAY:  prdata = {16'b0, stabilize_delay};
      fss_pkg::REG_MEASURE_INTERVAL: prdata = {16'b0, measure_interval};
      fss_pkg::REG_MIN_RPM:          prdata = {16'b0, min_rpm};
      fss_pkg::REG_MAX_RPM:          prdata = {16'b0, max_rpm};
      default:                       prdata = '0;
    endcase
  end

  // Handshake: the status register parts the two channels
  logic out_valid;
  logic accept;

  assign tick.ready   = !out_valid || status.ready;
  assign accept       = tick.valid && tick.ready;
  assign status.valid = out_valid;

  // Tachometer
  fss_pkg::tach_result_t tach;

  fss_tach u_tach (
    .clk              (clk),
    .rst              (rst),
    .advance          (accept),
    .level            (tick.tach_level),
    .measure_interval (measure_interval),
    .result           (tach)
  );

  // Supervisor
  fss_pkg::fan_state_t        mode;
  logic [fss_pkg::CNT_W-1:0]  phase_ticks;
  logic [fss_pkg::EDGE_W-1:0] start_edge_count;
  logic [fss_pkg::DRIVE_W-1:0] drive_value;

  fss_pkg::fan_state_t         mode_next;
  logic [fss_pkg::CNT_W-1:0]   phase_ticks_next;
  logic [fss_pkg::EDGE_W-1:0]  start_edge_count_next;
  logic [fss_pkg::DRIVE_W-1:0] drive_value_next;

  fss_pkg::fan_state_t         mode_cur;
  logic [fss_pkg::DRIVE_W-1:0] duty;
  logic [fss_pkg::CNT_W:0]     phase_inc;
  logic [fss_pkg::EDGE_W-1:0]  edges_inc;
  logic                        rpm_ok;

  always_comb begin
    duty = (tick.pwm_request[fss_pkg::REQ_W-1:fss_pkg::DRIVE_W] != '0) ?
           fss_pkg::DRIVE_FULL : tick.pwm_request[fss_pkg::DRIVE_W-1:0];
    // The range check sees the rpm as updated by this same tick
    rpm_ok = (tach.rpm >= {4'b0, min_rpm}) && (tach.rpm <= {4'b0, max_rpm});
    phase_inc = {1'b0, phase_ticks} + 1'b1;
    edges_inc = (tach.edge_seen && start_edge_count != '1) ?
                start_edge_count + 1'b1 : start_edge_count;

    mode_cur              = (duty == '0) ? fss_pkg::ST_IDLE : mode;
    mode_next             = mode_cur;
    phase_ticks_next      = phase_ticks;
    start_edge_count_next = start_edge_count;
    drive_value_next      = drive_value;

    case (mode_cur)
      fss_pkg::ST_IDLE: begin
        // The tick that leaves idle leaves the drive as it was.
        if (duty != '0) begin
          mode_next             = fss_pkg::ST_STARTING;
          start_edge_count_next = '0;
          phase_ticks_next      = '0;
        end else begin
          drive_value_next = '0;
        end
      end
      fss_pkg::ST_STARTING: begin
        phase_ticks_next = phase_inc[fss_pkg::CNT_W] ? '1 : phase_inc[fss_pkg::CNT_W-1:0];
        if (phase_inc > {1'b0, spinup_limit}) begin
          mode_next = fss_pkg::ST_START_ERR;
        end else begin
          drive_value_next      = fss_pkg::DRIVE_FULL;
          start_edge_count_next = edges_inc;
          if (edges_inc >= spinup_edges) begin
            mode_next        = fss_pkg::ST_STABILIZING;
            phase_ticks_next = '0;
          end
        end
      end
      fss_pkg::ST_STABILIZING: begin
        drive_value_next = duty;
        if (phase_ticks < stabilize_delay) begin
          phase_ticks_next = phase_inc[fss_pkg::CNT_W-1:0];
        end else begin
          mode_next = fss_pkg::ST_RUNNING;
        end
      end
      fss_pkg::ST_RUNNING: begin
        drive_value_next = duty;
        if (!rpm_ok) begin
          mode_next = fss_pkg::ST_RUN_ERR;
        end
      end
      default: begin
        drive_value_next = duty;
        if (rpm_ok) begin
          mode_next = fss_pkg::ST_RUNNING;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= fss_pkg::ST_IDLE;
      phase_ticks      <= '0;
      start_edge_count <= '0;
      drive_value      <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (accept) begin
        mode             <= mode_next;
        phase_ticks      <= phase_ticks_next;
        start_edge_count <= start_edge_count_next;
        drive_value      <= drive_value_next;
        out_valid        <= 1'b1;
      end else if (status.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Status payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      status.fan_state    <= mode_next;
      status.drive_level  <= drive_value_next;
      status.measured_rpm <= tach.rpm;
      status.tach_edge    <= tach.edge_seen;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fss_tach.sv
// ----------------------------------------------------------------------------
// Fan tachometer
// Counts pin level changes over a window of ticks and turns the count into rpm.
// ----------------------------------------------------------------------------
`default_nettype none

module fss_tach (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic                      level,
  input  wire logic [fss_pkg::CNT_W-1:0] measure_interval,
  output fss_pkg::tach_result_t          result
);

  logic                      prev_level;
  logic [fss_pkg::CNT_W-1:0] window_edges;
  logic [fss_pkg::CNT_W-1:0] window_ticks;
  logic [fss_pkg::RPM_W-1:0] rpm_value;

  logic                      prev_level_next;
  logic [fss_pkg::CNT_W-1:0] window_edges_next;
  logic [fss_pkg::CNT_W-1:0] window_ticks_next;
  logic [fss_pkg::RPM_W-1:0] rpm_value_next;

  logic                      edge_seen;
  logic [fss_pkg::CNT_W-1:0] edges_inc;
  logic [fss_pkg::CNT_W:0]   ticks_inc;
  logic [fss_pkg::CNT_W-3:0] quads;
  logic [fss_pkg::RPM_W-1:0] rpm_calc;

  always_comb begin
    edge_seen = level ^ prev_level;
    edges_inc = (edge_seen && window_edges != '1) ? window_edges + 1'b1 : window_edges;
    ticks_inc = {1'b0, window_ticks} + 1'b1;
    // Whole groups of four level changes count as revolutions: rpm = (edges / 4) * 64 - (edges / 4) * 4
    quads     = edges_inc[fss_pkg::CNT_W-1:2];
    rpm_calc  = ({quads, 6'b0}) - ({4'b0, quads, 2'b0});

    prev_level_next = level;
    // An interval of zero closes the window on every tick, as an interval of one
    if (ticks_inc >= {1'b0, measure_interval}) begin
      rpm_value_next    = rpm_calc;
      window_edges_next = '0;
      window_ticks_next = '0;
    end else begin
      rpm_value_next    = rpm_value;
      window_edges_next = edges_inc;
      window_ticks_next = ticks_inc[fss_pkg::CNT_W-1:0];
    end

    result.edge_seen = edge_seen;
    result.rpm       = rpm_value_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level   <= 1'b0;
      window_edges <= '0;
      window_ticks <= '0;
      rpm_value    <= '0;
    end else if (advance) begin
      prev_level   <= prev_level_next;
      window_edges <= window_edges_next;
      window_ticks <= window_ticks_next;
      rpm_value    <= rpm_value_next;
    end
  end

endmodule

`default_nettype wire

FILE: test/fan_supervisor_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fan supervisor status checker
// Watches the tick and status channels and the register port, keeps its own
// model of the tachometer and the spin-up state machine, and compares every
// status beat with the one predicted for the oldest outstanding tick.
// ----------------------------------------------------------------------------

module fan_supervisor_checker
  import fss_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  fss_tick_if                 tick,
  fss_status_if               status,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  input  logic                pready,
  output int unsigned         mismatch_count,
  output int unsigned         awaiting
);

  typedef struct packed {
    fan_state_t         state;
    logic [DRIVE_W-1:0] drive;
    logic [RPM_W-1:0]   rpm;
    logic               tach_edge;
  } status_beat_t;

  status_beat_t expected_status[$];
  int unsigned  fails;
  int unsigned  pending_n;

  // Register copies
  logic [15:0] cfg_spinup_limit;
  logic [7:0]  cfg_spinup_edges;
  logic [15:0] cfg_stabilize;
  logic [15:0] cfg_interval;
  logic [15:0] cfg_min_rpm;
  logic [15:0] cfg_max_rpm;

  // Fan and tachometer state
  fan_state_t  sv_mode;
  logic [15:0] phase_cnt;
  logic [7:0]  spin_edges;
  logic        last_level;
  logic [15:0] win_edges;
  logic [16:0] win_ticks;
  logic [19:0] rpm_now;
  logic [7:0]  drive_now;

  assign mismatch_count = fails;
  assign awaiting       = pending_n;

  task automatic advance_fan(input logic lvl, input logic [15:0] req,
                             output status_beat_t beat);
    logic [8:0]  duty;
    logic        edge_now;
    logic [16:0] next_ticks;
    logic        in_range;
    duty     = (req > 16'd255) ? 9'd255 : req[8:0];
    edge_now = lvl ^ last_level;

    if (edge_now && win_edges != 16'hFFFF) win_edges = win_edges + 16'd1;
    last_level = lvl;
    win_ticks  = win_ticks + 17'd1;
    // An interval of zero closes the window on every tick.
    if (win_ticks >= {1'b0, cfg_interval}) begin
      rpm_now   = 20'((32'(win_edges) >> 2) * 32'd60);
      win_edges = '0;
      win_ticks = '0;
    end
    in_range = (rpm_now >= 20'(cfg_min_rpm)) && (rpm_now <= 20'(cfg_max_rpm));

    if (duty == 9'd0) sv_mode = ST_IDLE;
    case (sv_mode)
      ST_IDLE: begin
        // The tick that leaves idle leaves the drive untouched.
        if (duty != 9'd0) begin
          sv_mode    = ST_STARTING;
          spin_edges = '0;
          phase_cnt  = '0;
        end else begin
          drive_now = '0;
        end
      end
      ST_STARTING: begin
        next_ticks = {1'b0, phase_cnt} + 17'd1;
        phase_cnt  = next_ticks[16] ? 16'hFFFF : next_ticks[15:0];
        if (next_ticks > {1'b0, cfg_spinup_limit}) begin
          sv_mode = ST_START_ERR;
        end else begin
          drive_now = DRIVE_FULL;
          if (edge_now && spin_edges != 8'hFF) spin_edges = spin_edges + 8'd1;
          if (spin_edges >= cfg_spinup_edges) begin
            sv_mode   = ST_STABILIZING;
            phase_cnt = '0;
          end
        end
      end
      ST_STABILIZING: begin
        drive_now = duty[7:0];
        if (phase_cnt < cfg_stabilize) phase_cnt = phase_cnt + 16'd1;
        else sv_mode = ST_RUNNING;
      end
      ST_RUNNING: begin
        drive_now = duty[7:0];
        if (!in_range) sv_mode = ST_RUN_ERR;
      end
      default: begin
        drive_now = duty[7:0];
        if (in_range) sv_mode = ST_RUNNING;
      end
    endcase

    beat.state     = sv_mode;
    beat.drive     = drive_now;
    beat.rpm       = rpm_now;
    beat.tach_edge = edge_now;
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    status_beat_t want;
    status_beat_t next_beat;
    if (rst) begin
      cfg_spinup_limit  = START_TIMEOUT_RST;
      cfg_spinup_edges  = START_EDGES_RST;
      cfg_stabilize     = STABILIZE_DELAY_RST;
      cfg_interval      = MEASURE_INTERVAL_RST;
      cfg_min_rpm       = MIN_RPM_RST;
      cfg_max_rpm       = MAX_RPM_RST;
      sv_mode           = ST_IDLE;
      phase_cnt         = '0;
      spin_edges        = '0;
      last_level        = 1'b0;
      win_edges         = '0;
      win_ticks         = '0;
      rpm_now           = '0;
      drive_now         = '0;
      expected_status.delete();
      fails             = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_START_TIMEOUT:    cfg_spinup_limit  = pwdata[15:0];
          REG_START_EDGES:      cfg_spinup_edges  = pwdata[7:0];
          REG_STABILIZE_DELAY:  cfg_stabilize     = pwdata[15:0];
          REG_MEASURE_INTERVAL: cfg_interval      = pwdata[15:0];
          REG_MIN_RPM:          cfg_min_rpm       = pwdata[15:0];
          REG_MAX_RPM:          cfg_max_rpm       = pwdata[15:0];
          default: ;
        endcase
      end

      // A status beat here always belongs to a tick taken in an earlier cycle.
      if (status.valid && status.ready) begin
        if (expected_status.size() == 0) begin
          $display("%0t: status beat with no tick outstanding, expected none, %s %0d %0d %0d %0d",
                   $time, "actual", status.fan_state, status.drive_level,
                   status.measured_rpm, status.tach_edge);
          fails++;
        end else begin
          want = expected_status.pop_front();
          check_field("fan_state", want.state, status.fan_state);
          check_field("drive_level", want.drive, status.drive_level);
          check_field("measured_rpm", want.rpm, status.measured_rpm);
          check_field("tach_edge", want.tach_edge, status.tach_edge);
        end
      end

      if (tick.valid && tick.ready) begin
        advance_fan(tick.tach_level, tick.pwm_request, next_beat);
        expected_status.push_back(next_beat);
      end
    end
    pending_n = expected_status.size();
  end

endmodule

FILE: test/fan_start_stall_supervisor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fan start and stall supervisor testbench
// Drives tachometer ticks shaped like a spinning, stalling or noisy fan under
// a range of register settings, with random gaps on both channels; the
// checker beside the block predicts and compares every status beat.
// ----------------------------------------------------------------------------

module fan_start_stall_supervisor_test;
  import fss_pkg::*;

  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_TICKS = 10;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  int unsigned       mismatch_count;
  int unsigned       awaiting;
  int unsigned       quiet_cycles = 0;
  bit                gaps_on = 1'b1;

  fss_tick_if   tick_ch ();
  fss_status_if status_ch ();

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fan_start_stall_supervisor dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  fan_supervisor_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick_ch),
    .status         (status_ch),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .mismatch_count (mismatch_count),
    .awaiting       (awaiting)
  );

  always @(negedge clk) begin
    status_ch.ready <= !gaps_on || ($urandom_range(99) >= 18);
  end

  // Watchdog on cycles in which no beat and no register access takes place.
  always @(posedge clk) begin
    if (rst || psel || (tick_ch.valid && tick_ch.ready) ||
        (status_ch.valid && status_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("FAIL fan_start_stall_supervisor");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // All driving tasks start and end at a falling edge.
  task automatic send_tick(input logic lvl, input logic [15:0] req);
    while (gaps_on && $urandom_range(99) < 18) @(negedge clk);
    tick_ch.valid       = 1'b1;
    tick_ch.tach_level  = lvl;
    tick_ch.pwm_request = req;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    @(negedge clk);
    tick_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic drain_status();
    tick_ch.valid = 1'b0;
    while (awaiting != 0) @(negedge clk);
  endtask

  // Unused upper data bits carry noise that the block must ignore.
  task automatic apply_settings(input int unsigned st, input int unsigned se,
                                input int unsigned sd, input int unsigned mi,
                                input int unsigned mn, input int unsigned mx);
    drain_status();
    write_reg(REG_START_TIMEOUT,    32'(st[15:0]) | ($urandom & 32'hFFFF_0000));
    write_reg(REG_START_EDGES,      32'(se[7:0])  | ($urandom & 32'hFFFF_FF00));
    write_reg(REG_STABILIZE_DELAY,  32'(sd[15:0]) | ($urandom & 32'hFFFF_0000));
    write_reg(REG_MEASURE_INTERVAL, 32'(mi[15:0]) | ($urandom & 32'hFFFF_0000));
    write_reg(REG_MIN_RPM,          32'(mn[15:0]) | ($urandom & 32'hFFFF_0000));
    write_reg(REG_MAX_RPM,          32'(mx[15:0]) | ($urandom & 32'hFFFF_0000));
  endtask

  // Segments of steady request with a fan spinning at some rate, or stalled,
  // now and then a zero request and a little pin noise.
  task automatic run_fan(input int unsigned beats);
    int unsigned seg_left;
    int unsigned period;
    int unsigned phase;
    logic [15:0] req;
    logic        lvl;
    seg_left = 0;
    period   = 1;
    phase    = 0;
    req      = 16'd1;
    lvl      = 1'b0;
    repeat (beats) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 5);
        case ($urandom_range(9))
          0: begin
            req      = 16'd0;
            seg_left = $urandom_range(4, 1);
          end
          1: req = 16'($urandom);
          2: req = $urandom_range(1) ? 16'd255 : 16'd256;
          default: req = 16'($urandom_range(255, 1));
        endcase
        period = $urandom_range(6);
      end
      seg_left--;
      if ($urandom_range(99) < 8) begin
        lvl = 1'($urandom);
      end else if (period != 0) begin
        phase++;
        if (phase >= period) begin
          phase = 0;
          lvl   = !lvl;
        end
      end
      send_tick(lvl, req);
    end
  endtask

  initial begin
    int unsigned lo;
    rst                 = 1'b1;
    tick_ch.valid       = 1'b0;
    tick_ch.tach_level  = 1'b0;
    tick_ch.pwm_request = '0;
    status_ch.ready     = 1'b0;
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Spin-up, stabilisation, running, start timeout and recovery, with the
    // window closing on every tick.
    apply_settings(3, 2, 2, 0, 0, 65535);
    send_tick(1'b0, 16'd0);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b1, 16'd256);
    send_tick(1'b1, 16'd255);
    send_tick(1'b1, 16'd1);
    send_tick(1'b1, 16'd1);
    send_tick(1'b1, 16'd128);
    send_tick(1'b1, 16'd0);
    repeat (6) send_tick(1'b1, 16'd300);
    send_tick(1'b0, 16'd300);

    // No start edges needed, and limits that no rpm can satisfy.
    apply_settings(5, 0, 0, 2, 100, 50);
    send_tick(1'b0, 16'd0);
    send_tick(1'b0, 16'd40);
    send_tick(1'b1, 16'd40);
    send_tick(1'b0, 16'd40);
    send_tick(1'b1, 16'd40);
    send_tick(1'b0, 16'h8000);
    send_tick(1'b0, 16'd0);

    for (int p = 0; p < 5; p++) begin
      gaps_on = (p != 2);
      lo = $urandom_range(200);
      if (p == 4)
        apply_settings($urandom_range(40), $urandom_range(10), $urandom_range(20),
                       $urandom_range(30), 300, 100);
      else
        apply_settings($urandom_range(40), $urandom_range(10), $urandom_range(20),
                       $urandom_range(30), lo, lo + $urandom_range(300));
      run_fan(230);
    end
    gaps_on = 1'b1;

    apply_settings(0, 0, 0, 0, 0, 0);
    run_fan(40);
    apply_settings(65535, 255, 65535, 65535, 65535, 65535);
    run_fan(40);

    drain_status();
    repeat (DRAIN_TICKS) @(negedge clk);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("PASS fan_start_stall_supervisor");
    end else begin
      $display("FAIL fan_start_stall_supervisor");
    end
    $finish;
  end

endmodule
